// File: rtl/imhq_pkg.sv
// Shared types and codes for the indexed min-heap priority queue.
package imhq_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_SET_KEY = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_DEL_MIN = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_FETCH,
    S_FETCH_WAIT,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_WAIT,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_e;

  localparam int unsigned IdBits   = 8;
  localparam int unsigned CapBits  = 7;
  localparam int unsigned DataBits = 32;

endpackage

// File: rtl/imhq_heap_mem.sv
// Heap slot memory: key, id and payload per slot, two read ports, one write port.
module imhq_heap_mem import imhq_pkg::*; #(
  parameter int unsigned Depth   = 64,
  parameter int unsigned KeyBits = 32,
  parameter int unsigned PosBits = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [PosBits-1:0]  waddr_i,
  input  logic [KeyBits-1:0]  wkey_i,
  input  logic [IdBits-1:0]   wid_i,
  input  logic [DataBits-1:0] wpl_i,
  input  logic [PosBits-1:0]  raddr_a_i,
  input  logic [PosBits-1:0]  raddr_b_i,
  output logic [KeyBits-1:0]  rkey_a_o,
  output logic [IdBits-1:0]   rid_a_o,
  output logic [DataBits-1:0] rpl_a_o,
  output logic [KeyBits-1:0]  rkey_b_o,
  output logic [IdBits-1:0]   rid_b_o,
  output logic [DataBits-1:0] rpl_b_o
);

  logic [KeyBits-1:0]  key_mem [Depth];
  logic [IdBits-1:0]   id_mem  [Depth];
  logic [DataBits-1:0] pl_mem  [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      id_mem[waddr_i]  <= wid_i;
      pl_mem[waddr_i]  <= wpl_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rkey_a_o <= key_mem[raddr_a_i];
    rid_a_o  <= id_mem[raddr_a_i];
    rpl_a_o  <= pl_mem[raddr_a_i];
    rkey_b_o <= key_mem[raddr_b_i];
    rid_b_o  <= id_mem[raddr_b_i];
    rpl_b_o  <= pl_mem[raddr_b_i];
  end

endmodule

// File: rtl/imhq_pos_table.sv
// Id table: heap position memory plus present bits cleared at reset.
module imhq_pos_table import imhq_pkg::*; #(
  parameter int unsigned IdCount = 256,
  parameter int unsigned PosBits = 6,
  parameter int unsigned IdxBits = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pos_we_i,
  input  logic [IdxBits-1:0] pos_waddr_i,
  input  logic [PosBits-1:0] pos_wdata_i,
  input  logic [IdxBits-1:0] raddr_i,
  output logic [PosBits-1:0] pos_o,
  output logic               present_o,
  input  logic               pres_we_i,
  input  logic [IdxBits-1:0] pres_waddr_i,
  input  logic               pres_wdata_i
);

  logic [PosBits-1:0] pos_mem [IdCount];
  logic [IdCount-1:0] present_q;

  always_ff @(posedge clk_i) begin
    if (pos_we_i) begin
      pos_mem[pos_waddr_i] <= pos_wdata_i;
    end
    pos_o <= pos_mem[raddr_i];
  end

  // present flags, one per id
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      present_o <= 1'b0;
    end else begin
      if (pres_we_i) begin
        present_q[pres_waddr_i] <= pres_wdata_i;
      end
      present_o <= present_q[raddr_i];
    end
  end

endmodule

// File: rtl/indexed_min_heap_queue_top.sv
// Top level of the indexed min-heap priority queue: command sequencer and result port.
//
// Usage: drive command_i, item_id_i, key_in_i and payload_in_i and raise start_i;
// the command is taken at the edge where start_i is high and busy_o is low.
// Every command yields one result: status_o, id_out_o, key_out_o and
// payload_out_o are valid for the single cycle in which done_o is high. The
// receiver cannot stall, so the result must be captured in that cycle.
// The capacity register is written through cfg_valid_i/cfg_ready_o/cfg_data_i;
// cfg_ready_o is high while no command is in flight.
// A command that fails ends after the id table lookup. A successful command
// runs a setup and then one sift walk: each upward level reads the parent and
// compares, each downward level reads both children from the heap memory,
// waits, compares and writes back.
// One command is in flight at a time; busy_o stays high until done_o.
// Reset clears the present flags, entry count and state, and sets the
// capacity to 64. Heap slots and positions need no clearing.
module indexed_min_heap_queue_top import imhq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = 64,
  parameter int unsigned ID_COUNT   = 256,
  parameter int unsigned KEY_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          command_i,
  input  logic [IdBits-1:0]   item_id_i,
  input  logic signed [31:0]  key_in_i,
  input  logic [DataBits-1:0] payload_in_i,
  output logic                done_o,
  output logic [2:0]          status_o,
  output logic [IdBits-1:0]   id_out_o,
  output logic signed [31:0]  key_out_o,
  output logic [DataBits-1:0] payload_out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CapBits-1:0]  cfg_data_i
);

  localparam int unsigned PosBits = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned IdxBits = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int unsigned WBits   = (CntBits > CapBits ? CntBits : CapBits) + 1;
  localparam logic [KEY_BITS-1:0] KeySign = {1'b1, {(KEY_BITS-1){1'b0}}};

  state_e state_q, state_d;
  cmd_e   cmd_q;
  logic [IdBits-1:0]   in_id_q;
  logic [KEY_BITS-1:0] in_key_q;
  logic [DataBits-1:0] in_pl_q;
  logic [CntBits-1:0]  count_q, count_d;
  logic [CapBits-1:0]  cap_q;

  // carried entry and walk position
  logic [KEY_BITS-1:0] k_q, k_d;
  logic [IdBits-1:0]   cid_q, cid_d;
  logic [DataBits-1:0] cpl_q, cpl_d;
  logic [PosBits-1:0]  pos_q, pos_d;
  logic [KEY_BITS-1:0] old_q, old_d;
  logic                up_q, up_d;

  logic                done_q, done_d;
  status_e             st_q, st_d;
  logic [IdBits-1:0]   oid_q, oid_d;
  logic [KEY_BITS-1:0] okey_q, okey_d;
  logic [DataBits-1:0] opl_q, opl_d;

  // memory ports
  logic                we;
  logic [PosBits-1:0]  waddr, raddr_a, raddr_b;
  logic [KEY_BITS-1:0] wkey, rkey_a, rkey_b;
  logic [IdBits-1:0]   wid, rid_a, rid_b;
  logic [DataBits-1:0] wpl, rpl_a, rpl_b;
  logic                pos_we, pres_we, pres_wd, present;
  logic [IdxBits-1:0]  pos_waddr, pres_waddr, tab_raddr;
  logic [PosBits-1:0]  pos_wd, pos_rd;

  logic                accept, known;
  logic [CntBits-1:0]  cap_eff;
  logic [WBits-1:0]    lchild, rchild;
  logic [PosBits-1:0]  parent;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign known       = (32'(in_id_q) < 32'(ID_COUNT));
  assign cap_eff     = (WBits'(cap_q) > WBits'(HEAP_DEPTH)) ? CntBits'(HEAP_DEPTH)
                                                           : CntBits'(cap_q);
  assign lchild      = WBits'({pos_q, 1'b1});
  assign rchild      = lchild + WBits'(1);
  assign parent      = (pos_q - PosBits'(1)) >> 1;

  imhq_heap_mem #(.Depth(HEAP_DEPTH), .KeyBits(KEY_BITS), .PosBits(PosBits)) u_heap (
    .clk_i, .we_i(we), .waddr_i(waddr), .wkey_i(wkey), .wid_i(wid), .wpl_i(wpl),
    .raddr_a_i(raddr_a), .raddr_b_i(raddr_b),
    .rkey_a_o(rkey_a), .rid_a_o(rid_a), .rpl_a_o(rpl_a),
    .rkey_b_o(rkey_b), .rid_b_o(rid_b), .rpl_b_o(rpl_b)
  );

  imhq_pos_table #(.IdCount(ID_COUNT), .PosBits(PosBits), .IdxBits(IdxBits)) u_tab (
    .clk_i, .rst_ni,
    .pos_we_i(pos_we), .pos_waddr_i(pos_waddr), .pos_wdata_i(pos_wd),
    .raddr_i(tab_raddr), .pos_o(pos_rd), .present_o(present),
    .pres_we_i(pres_we), .pres_waddr_i(pres_waddr), .pres_wdata_i(pres_wd)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      cap_q   <= CapBits'(64);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // command and walk payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_e'(command_i);
      in_id_q  <= item_id_i;
      in_key_q <= KEY_BITS'(key_in_i) ^ KeySign;
      in_pl_q  <= payload_in_i;
    end
    k_q    <= k_d;
    cid_q  <= cid_d;
    cpl_q  <= cpl_d;
    pos_q  <= pos_d;
    old_q  <= old_d;
    up_q   <= up_d;
    st_q   <= st_d;
    oid_q  <= oid_d;
    okey_q <= okey_d;
    opl_q  <= opl_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    k_d = k_q; cid_d = cid_q; cpl_d = cpl_q; pos_d = pos_q; old_d = old_q; up_d = up_q;
    done_d = 1'b0;
    st_d = st_q; oid_d = oid_q; okey_d = okey_q; opl_d = opl_q;
    we = 1'b0; waddr = pos_q; wkey = k_q; wid = cid_q; wpl = cpl_q;
    raddr_a = pos_q; raddr_b = pos_q;
    pos_we = 1'b0; pos_waddr = IdxBits'(cid_q); pos_wd = pos_q;
    pres_we = 1'b0; pres_waddr = IdxBits'(in_id_q); pres_wd = 1'b0;
    tab_raddr = IdxBits'(in_id_q);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d = ST_OK; oid_d = '0; okey_d = '0; opl_d = '0;
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        // table read issued this cycle; delete-min reads slot 0 and last
        raddr_a = '0;
        raddr_b = PosBits'(count_q - CntBits'(1));
        state_d = S_FETCH;
      end
      S_FETCH: begin
        state_d = S_DONE;
        case (cmd_q)
          CMD_INSERT: begin
            if (count_q >= cap_eff) st_d = ST_FULL;
            else if (!known) st_d = ST_NOT_FOUND;
            else if (present) st_d = ST_DUPLICATE;
            else begin
              pres_we = 1'b1; pres_wd = 1'b1;
              k_d = in_key_q; cid_d = in_id_q; cpl_d = in_pl_q;
              pos_d = PosBits'(count_q);
              count_d = count_q + CntBits'(1);
              state_d = S_UP_RD;
            end
          end
          CMD_SET_KEY, CMD_REMOVE: begin
            if (!known || !present) st_d = ST_NOT_FOUND;
            else begin
              raddr_a = pos_rd;
              raddr_b = PosBits'(count_q - CntBits'(1));
              pos_d = pos_rd;
              state_d = S_FETCH_WAIT;
            end
          end
          default: begin
            if (count_q == '0) st_d = ST_EMPTY;
            else begin
              oid_d = rid_a; okey_d = rkey_a ^ KeySign; opl_d = rpl_a;
              pres_we = 1'b1; pres_waddr = IdxBits'(rid_a);
              count_d = count_q - CntBits'(1);
              k_d = rkey_b; cid_d = rid_b; cpl_d = rpl_b;
              pos_d = '0;
              state_d = (count_q == CntBits'(1)) ? S_DONE : S_DN_RD;
            end
          end
        endcase
      end
      S_FETCH_WAIT: begin
        old_d = rkey_a;
        if (cmd_q == CMD_SET_KEY) begin
          k_d = in_key_q; cid_d = rid_a; cpl_d = rpl_a;
          if (rkey_a < in_key_q) state_d = S_DN_RD;
          else if (rkey_a > in_key_q) state_d = S_UP_RD;
          else state_d = S_PLACE;
        end else begin
          oid_d = in_id_q; okey_d = rkey_a ^ KeySign; opl_d = rpl_a;
          pres_we = 1'b1;
          count_d = count_q - CntBits'(1);
          k_d = rkey_b; cid_d = rid_b; cpl_d = rpl_b;
          if (CntBits'(pos_q) == count_q - CntBits'(1)) state_d = S_DONE;
          else if (rkey_b < rkey_a) state_d = S_UP_RD;
          else if (rkey_b > rkey_a) state_d = S_DN_RD;
          else state_d = S_PLACE;
        end
      end
      S_UP_RD: begin
        raddr_a = parent;
        state_d = (pos_q == '0) ? S_PLACE : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (k_q < rkey_a) begin
          // parent moves down into the hole
          we = 1'b1; wkey = rkey_a; wid = rid_a; wpl = rpl_a;
          pos_we = 1'b1; pos_waddr = IdxBits'(rid_a);
          pos_d = parent;
          state_d = S_UP_RD;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DN_RD: begin
        raddr_a = lchild[PosBits-1:0];
        raddr_b = rchild[PosBits-1:0];
        state_d = (lchild >= WBits'(count_q)) ? S_PLACE : S_DN_WAIT;
      end
      S_DN_WAIT: begin
        // keep both children on the read ports for the compare cycle
        raddr_a = lchild[PosBits-1:0];
        raddr_b = rchild[PosBits-1:0];
        up_d = (rchild < WBits'(count_q)) && (rkey_b < rkey_a);
        old_d = up_d ? rkey_b : rkey_a;
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        raddr_a = lchild[PosBits-1:0];
        raddr_b = rchild[PosBits-1:0];
        state_d = S_PLACE;
        if (old_q < k_q) begin
          we = 1'b1;
          wkey = up_q ? rkey_b : rkey_a;
          wid  = up_q ? rid_b : rid_a;
          wpl  = up_q ? rpl_b : rpl_a;
          pos_we = 1'b1; pos_waddr = IdxBits'(wid);
          pos_d = up_q ? rchild[PosBits-1:0] : lchild[PosBits-1:0];
          state_d = S_DN_RD;
        end
      end
      S_PLACE: begin
        we = 1'b1; pos_we = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result port: done_q rises in the cycle after S_DONE, state back in idle
  assign done_o        = done_q;
  assign status_o      = st_q;
  assign id_out_o      = oid_q;
  assign key_out_o     = 32'($signed(okey_q));
  assign payload_out_o = opl_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(HEAP_DEPTH))
    else $error("entry count exceeds heap depth");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held two cycles");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == S_IDLE))
    else $error("result issued while busy");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (key_out_o == '0 && payload_out_o == '0))
    else $error("failed command returned data");
`endif

endmodule

// File: bench/indexed_min_heap_queue_top_tb.sv
// Self-checking testbench for the indexed min-heap priority queue top level.
`timescale 1ns / 1ps

module indexed_min_heap_queue_top_tb;
  import imhq_pkg::*;

  localparam int unsigned Depth     = 64;
  localparam int unsigned Ids       = 256;
  localparam int unsigned CycleCap  = 400000;
  localparam int unsigned DrainWait = 40;

  // One expected result
  typedef struct packed {
    status_e     status;
    logic [7:0]  id;
    logic [31:0] key;
    logic [31:0] payload;
  } heap_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         command_i;
  logic [7:0]         item_id_i;
  logic signed [31:0] key_in_i;
  logic [31:0]        payload_in_i;
  logic               done_o;
  logic [2:0]         status_o;
  logic [7:0]         id_out_o;
  logic signed [31:0] key_out_o;
  logic [31:0]        payload_out_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [6:0]         cfg_data_i;

  // Predictor state: keys held as signed values
  logic signed [31:0] pq_key [Depth];
  logic [7:0]         pq_id  [Depth];
  logic [31:0]        pq_pl  [Depth];
  int unsigned        slot_of [Ids];
  bit                 is_held [Ids];
  int unsigned        held_count;
  int unsigned        cap_reg;

  heap_result_t pending_results[$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  bit           allow_idle;

  indexed_min_heap_queue_top uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .item_id_i, .key_in_i,
    .payload_in_i, .done_o, .status_o, .id_out_o, .key_out_o, .payload_out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("indexed_min_heap_queue_top_tb: done, errors");
      $finish;
    end
  end

  task automatic report(input string what);
    error_count++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  function automatic void place(input int unsigned pos, input logic signed [31:0] k,
                                input logic [7:0] id, input logic [31:0] pl);
    pq_key[pos] = k;
    pq_id[pos] = id;
    pq_pl[pos] = pl;
    slot_of[id] = pos;
  endfunction

  function automatic void bubble_up(input int unsigned start_pos);
    int unsigned pos;
    int unsigned par;
    logic signed [31:0] k;
    logic [7:0] id;
    logic [31:0] pl;
    pos = start_pos;
    k = pq_key[pos];
    id = pq_id[pos];
    pl = pq_pl[pos];
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (!(k < pq_key[par])) break;
      place(pos, pq_key[par], pq_id[par], pq_pl[par]);
      pos = par;
    end
    place(pos, k, id, pl);
  endfunction

  function automatic void bubble_down(input int unsigned start_pos);
    int unsigned pos;
    int unsigned l;
    int unsigned c;
    logic signed [31:0] k;
    logic [7:0] id;
    logic [31:0] pl;
    pos = start_pos;
    k = pq_key[pos];
    id = pq_id[pos];
    pl = pq_pl[pos];
    forever begin
      l = 2 * pos + 1;
      if (l >= held_count) break;
      c = l;
      if (l + 1 < held_count && pq_key[l + 1] < pq_key[l]) c = l + 1;
      if (!(pq_key[c] < k)) break;
      place(pos, pq_key[c], pq_id[c], pq_pl[c]);
      pos = c;
    end
    place(pos, k, id, pl);
  endfunction

  // Predict the result of one command and update the queue image
  function automatic heap_result_t queue_outcome(input cmd_e cmd, input logic [7:0] id,
                                                 input logic signed [31:0] k,
                                                 input logic [31:0] pl);
    heap_result_t r;
    int unsigned cap;
    int unsigned pos;
    int unsigned last;
    logic signed [31:0] old;
    logic signed [31:0] nk;
    r = '{ST_OK, 8'd0, 32'd0, 32'd0};
    cap = (cap_reg > Depth) ? Depth : cap_reg;
    case (cmd)
      CMD_INSERT: begin
        if (held_count >= cap) r.status = ST_FULL;
        else if (is_held[id]) r.status = ST_DUPLICATE;
        else begin
          is_held[id] = 1'b1;
          place(held_count, k, id, pl);
          held_count++;
          bubble_up(held_count - 1);
        end
      end
      CMD_SET_KEY: begin
        if (!is_held[id]) r.status = ST_NOT_FOUND;
        else begin
          pos = slot_of[id];
          old = pq_key[pos];
          pq_key[pos] = k;
          if (old < k) bubble_down(pos);
          else if (old > k) bubble_up(pos);
        end
      end
      CMD_REMOVE: begin
        if (!is_held[id]) r.status = ST_NOT_FOUND;
        else begin
          pos = slot_of[id];
          last = held_count - 1;
          old = pq_key[pos];
          r.id = id;
          r.key = old;
          r.payload = pq_pl[pos];
          is_held[id] = 1'b0;
          held_count = last;
          if (pos != last) begin
            nk = pq_key[last];
            place(pos, nk, pq_id[last], pq_pl[last]);
            if (nk < old) bubble_up(pos);
            else if (nk > old) bubble_down(pos);
          end
        end
      end
      default: begin
        if (held_count == 0) r.status = ST_EMPTY;
        else begin
          last = held_count - 1;
          r.id = pq_id[0];
          r.key = pq_key[0];
          r.payload = pq_pl[0];
          is_held[pq_id[0]] = 1'b0;
          held_count = last;
          if (last != 0) begin
            place(0, pq_key[last], pq_id[last], pq_pl[last]);
            bubble_down(0);
          end
        end
      end
    endcase
    return r;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    heap_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result status %0d", status_o));
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o !== exp_r.status)
          report($sformatf("status %0d, want %0d", status_o, exp_r.status));
        if (id_out_o !== exp_r.id)
          report($sformatf("id %0d, want %0d", id_out_o, exp_r.id));
        if (key_out_o !== exp_r.key)
          report($sformatf("key %0d, want %0d", key_out_o, $signed(exp_r.key)));
        if (payload_out_o !== exp_r.payload)
          report($sformatf("payload %h, want %h", payload_out_o, exp_r.payload));
      end
    end
  end

  task automatic idle_burst();
    if (allow_idle && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) @(posedge clk_i);
  endtask

  // Send one command; the transfer happens when start is high and busy is low
  task automatic send_command(input cmd_e cmd, input logic [7:0] id,
                              input logic signed [31:0] k, input logic [31:0] pl);
    idle_burst();
    start_i <= 1'b1;
    command_i <= cmd;
    item_id_i <= id;
    key_in_i <= k;
    payload_in_i <= pl;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(queue_outcome(cmd, id, k, pl));
    start_i <= 1'b0;
    // the block is busy for this cycle anyway
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_capacity(input int unsigned value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value[6:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_reg = value & 7'h7f;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] held_id_pick();
    int unsigned tries;
    logic [7:0] id;
    for (tries = 0; tries < 16; tries++) begin
      id = $urandom_range(0, 255);
      if (is_held[id]) return id;
    end
    return id;
  endfunction

  // Extremes, every command and the named corner cases
  task automatic test_directed();
    send_command(CMD_DEL_MIN, 8'd0, 0, 0);
    send_command(CMD_REMOVE, 8'd5, 0, 0);
    send_command(CMD_SET_KEY, 8'd255, 0, 0);
    send_command(CMD_INSERT, 8'd255, 32'sh7fffffff, 32'hffffffff);
    send_command(CMD_INSERT, 8'd0, 32'sh80000000, 32'h0);
    send_command(CMD_INSERT, 8'd0, 5, 1);
    send_command(CMD_INSERT, 8'd10, 7, 32'h5555aaaa);
    send_command(CMD_INSERT, 8'd11, 7, 32'haaaa5555);
    send_command(CMD_INSERT, 8'd12, -3, 32'h12345678);
    send_command(CMD_SET_KEY, 8'd10, 7, 0);
    send_command(CMD_SET_KEY, 8'd12, 100, 0);
    send_command(CMD_SET_KEY, 8'd255, -100, 0);
    send_command(CMD_REMOVE, 8'd11, 0, 0);
    send_command(CMD_REMOVE, 8'd0, 0, 0);
    repeat (5) send_command(CMD_DEL_MIN, 8'd0, 0, 0);
    write_capacity(0);
    send_command(CMD_INSERT, 8'd1, 1, 1);
    write_capacity(1);
    send_command(CMD_INSERT, 8'd1, 1, 1);
    send_command(CMD_INSERT, 8'd1, 2, 2);
    send_command(CMD_INSERT, 8'd2, 2, 2);
    send_command(CMD_REMOVE, 8'd1, 0, 0);
    write_capacity(127);
  endtask

  // Random traffic with a given capacity; keys from a narrow range often so ties occur
  task automatic test_random(input int unsigned count, input int unsigned cap);
    int unsigned n;
    int unsigned sel;
    logic [7:0] id;
    logic signed [31:0] k;
    write_capacity(cap);
    for (n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      k = ($urandom_range(0, 1)) ? $signed($urandom) : $signed($urandom_range(0, 15)) - 8;
      if (sel < 40) begin
        id = (held_count > 0 && $urandom_range(0, 9) == 0) ? held_id_pick() :
             8'($urandom_range(0, 255));
        send_command(CMD_INSERT, id, k, $urandom);
      end else if (sel < 62) begin
        id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : held_id_pick();
        send_command(CMD_SET_KEY, id, k, $urandom);
      end else if (sel < 80) begin
        id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : held_id_pick();
        send_command(CMD_REMOVE, id, k, $urandom);
      end else begin
        send_command(CMD_DEL_MIN, 8'($urandom), k, $urandom);
      end
      if (n == count / 2) drain();
    end
  endtask

  // Fill to the limit then empty by delete minimum, checking order
  task automatic test_fill_and_empty();
    int unsigned n;
    write_capacity(64);
    for (n = 0; n < 70; n++) send_command(CMD_INSERT, 8'(n * 3), $signed($urandom), $urandom);
    for (n = 0; n < 66; n++) send_command(CMD_DEL_MIN, 8'd0, 0, 0);
  endtask

  initial begin
    start_i = 1'b0;
    command_i = CMD_INSERT;
    item_id_i = '0;
    key_in_i = '0;
    payload_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    cycle_count = 0;
    error_count = 0;
    held_count = 0;
    cap_reg = 64;
    allow_idle = 1'b1;
    foreach (is_held[i]) is_held[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(250, 64);
    test_random(250, 8);
    test_random(200, 2);
    test_fill_and_empty();
    test_random(150, 100);
    allow_idle = 1'b0;
    test_random(250, 40);
    drain();

    if (error_count == 0) begin
      $display("indexed_min_heap_queue_top_tb: done, clean");
    end else begin
      $display("indexed_min_heap_queue_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/imhq_pkg.sv
rtl/imhq_heap_mem.sv
rtl/imhq_pos_table.sv
rtl/indexed_min_heap_queue_top.sv
bench/indexed_min_heap_queue_top_tb.sv
